### sv/tcc_pkg.sv
// tcc_pkg: shared types, constants and a helper function for the tick count
// to calendar block. Used by the controller and the datapath.
`default_nettype none

package tcc_pkg;

    // datapath command codes
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD_IN   = 4'd1;
    localparam logic [3:0] OP_STEP      = 4'd2;
    localparam logic [3:0] OP_LOAD_DAY  = 4'd3;
    localparam logic [3:0] OP_LOAD_CYC  = 4'd4;
    localparam logic [3:0] OP_LOAD_HR   = 4'd5;
    localparam logic [3:0] OP_LOAD_MIN  = 4'd6;
    localparam logic [3:0] OP_SAVE_TIME = 4'd7;
    localparam logic [3:0] OP_CENT      = 4'd8;
    localparam logic [3:0] OP_QUAD      = 4'd9;
    localparam logic [3:0] OP_YEAR      = 4'd10;
    localparam logic [3:0] OP_MON       = 4'd11;
    localparam logic [3:0] OP_PUBLISH   = 4'd12;

    // divisors
    localparam logic [23:0] SEC_TICKS  = 24'd10000000;
    localparam logic [23:0] DAY_SECS   = 24'd86400;
    localparam logic [23:0] CYCLE_DAYS = 24'd146097;
    localparam logic [23:0] HOUR_SECS  = 24'd3600;
    localparam logic [23:0] MIN_SECS   = 24'd60;

    // calendar constants
    localparam logic [15:0] EPOCH_YEAR = 16'd1601;
    localparam logic [17:0] CENT_DAYS  = 18'd36524;
    localparam logic [17:0] QUAD_DAYS  = 18'd1461;
    localparam logic [17:0] YEAR_DAYS  = 18'd365;

    // step counts per division pass, two quotient bits per cycle, minus one
    localparam logic [4:0] STEPS_SEC = 5'd31;
    localparam logic [4:0] STEPS_DAY = 5'd20;
    localparam logic [4:0] STEPS_CYC = 5'd12;
    localparam logic [4:0] STEPS_HR  = 5'd8;
    localparam logic [4:0] STEPS_MIN = 5'd5;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic cent_more;
        logic quad_more;
        logic year_more;
        logic mon_more;
    } dp_stat_t;

    // length of a month, month 0 is January
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                4'd1:                      len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

### sv/tick_count_to_calendar.sv
// Tick count to calendar converter, top level.
// Input channel: ticks (64-bit count of 100 ns ticks since 1601-01-01 00:00)
// with ticks_valid / ticks_stall; an item is taken at a clock edge with
// ticks_valid high and ticks_stall low.
// Output channel: year, month, day_of_month, hour_twelve, minute, second,
// is_pm with result_valid / result_stall, one result item per input item.
// The time to result_valid is set by one shared divider retiring two quotient
// bits per cycle (five passes: seconds, days, 400-year cycles, hours,
// minutes, with a load step after each pass) and a calendar walk of up to 3
// centuries, 24 four-year blocks, 3 years and 11 months, one step per cycle,
// a step to leave each of the four walk stages and a publish step. One item
// is in work at a time and the next is taken in the cycle after publish.
// Results sit in an output register: a new item is taken while an earlier
// result is still stalled, and the finished item waits in the last step
// until the output register is free. ticks_stall stays high while busy.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// result_valid; no other state is kept. Depends on tcc_pkg, tcc_ctrl and
// tcc_datapath.
`default_nettype none

module tick_count_to_calendar (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        ticks_valid,
    output logic             ticks_stall,
    input  wire logic [63:0] ticks,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day_of_month,
    output logic [3:0]       hour_twelve,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic             is_pm
);

    tcc_pkg::dp_cmd_t  cmd;
    tcc_pkg::dp_stat_t stat;

    // sequencer
    tcc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .ticks_valid  (ticks_valid),
        .ticks_stall  (ticks_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    // divider, walk and result registers
    tcc_datapath u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .stat         (stat),
        .ticks        (ticks),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour_twelve  (hour_twelve),
        .minute       (minute),
        .second       (second),
        .is_pm        (is_pm)
    );

endmodule

`default_nettype wire

### sv/tcc_datapath.sv
// tcc_datapath: shared radix-4 divider, year and month walk registers and
// result registers. Driven by tcc_ctrl through tcc_pkg command codes.
`default_nettype none

module tcc_datapath (
    input  wire logic             clk,
    input  wire tcc_pkg::dp_cmd_t cmd,
    output tcc_pkg::dp_stat_t     stat,
    input  wire logic [63:0]      ticks,
    output logic [15:0]           year,
    output logic [3:0]            month,
    output logic [4:0]            day_of_month,
    output logic [3:0]            hour_twelve,
    output logic [5:0]            minute,
    output logic [5:0]            second,
    output logic                  is_pm
);

    // divider state
    logic [63:0] dq_reg, dq_next;
    logic [23:0] rem_reg, rem_next;
    logic [23:0] div_reg, div_next;

    // partial results
    logic [16:0] tod_reg, tod_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;

    // calendar walk
    logic [15:0] yr_reg, yr_next;
    logic [17:0] days_reg, days_next;
    logic [1:0]  cent_idx_reg, cent_idx_next;
    logic [4:0]  quad_idx_reg, quad_idx_next;
    logic [1:0]  yr_idx_reg, yr_idx_next;
    logic [3:0]  mon_reg, mon_next;

    // output registers
    logic [15:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  dom_reg, dom_next;
    logic [3:0]  h12_reg, h12_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic        pm_reg, pm_next;

    // two restoring division steps
    logic [24:0] r1, r1s, r2, r2s;
    logic        q1, q2;
    logic [24:0] dext;

    // walk helpers
    logic        leap;
    logic [4:0]  mlen;
    logic [15:0] cyc_years;
    logic [4:0]  hour_lo;
    logic        hour_pm;

    always_comb
    begin
        dext = {1'b0, div_reg};
        r1   = {rem_reg, dq_reg[63]};
        q1   = (r1 >= dext);
        r1s  = q1 ? (r1 - dext) : r1;
        r2   = {r1s[23:0], dq_reg[62]};
        q2   = (r2 >= dext);
        r2s  = q2 ? (r2 - dext) : r2;
    end

    // leap flag of the current year, month length, status
    always_comb
    begin
        leap = (yr_idx_reg == 2'd3) && ((quad_idx_reg != 5'd24) || (cent_idx_reg == 2'd3));
        mlen = tcc_pkg::month_len(mon_reg, leap);
        stat.cent_more = (cent_idx_reg != 2'd3) && (days_reg >= tcc_pkg::CENT_DAYS);
        stat.quad_more = (days_reg >= tcc_pkg::QUAD_DAYS);
        stat.year_more = (yr_idx_reg != 2'd3) && (days_reg >= tcc_pkg::YEAR_DAYS);
        stat.mon_more  = (mon_reg != 4'd11) && (days_reg >= {13'd0, mlen});
    end

    // 400 years per cycle as shifts, cycle count at most 146
    always_comb
    begin
        cyc_years = ({8'd0, dq_reg[7:0]} << 8) + ({8'd0, dq_reg[7:0]} << 7)
                  + ({8'd0, dq_reg[7:0]} << 4);
    end

    // 12-hour clock
    always_comb
    begin
        hour_pm = (hour_reg >= 5'd12);
        hour_lo = hour_pm ? (hour_reg - 5'd12) : hour_reg;
    end

    // command decoder
    always_comb
    begin
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        tod_next      = tod_reg;
        hour_next     = hour_reg;
        min_next      = min_reg;
        sec_next      = sec_reg;
        yr_next       = yr_reg;
        days_next     = days_reg;
        cent_idx_next = cent_idx_reg;
        quad_idx_next = quad_idx_reg;
        yr_idx_next   = yr_idx_reg;
        mon_next      = mon_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        dom_next      = dom_reg;
        h12_next      = h12_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        pm_next       = pm_reg;
        unique case (cmd.op)
            tcc_pkg::OP_LOAD_IN:
            begin
                dq_next  = ticks;
                rem_next = 24'd0;
                div_next = tcc_pkg::SEC_TICKS;
            end
            tcc_pkg::OP_STEP:
            begin
                dq_next  = {dq_reg[61:0], q1, q2};
                rem_next = r2s[23:0];
            end
            tcc_pkg::OP_LOAD_DAY:
            begin
                dq_next  = {dq_reg[41:0], 22'd0};
                rem_next = 24'd0;
                div_next = tcc_pkg::DAY_SECS;
            end
            tcc_pkg::OP_LOAD_CYC:
            begin
                tod_next = rem_reg[16:0];
                dq_next  = {dq_reg[25:0], 38'd0};
                rem_next = 24'd0;
                div_next = tcc_pkg::CYCLE_DAYS;
            end
            tcc_pkg::OP_LOAD_HR:
            begin
                yr_next       = tcc_pkg::EPOCH_YEAR + cyc_years;
                days_next     = rem_reg[17:0];
                cent_idx_next = 2'd0;
                quad_idx_next = 5'd0;
                yr_idx_next   = 2'd0;
                mon_next      = 4'd0;
                dq_next       = {1'b0, tod_reg, 46'd0};
                rem_next      = 24'd0;
                div_next      = tcc_pkg::HOUR_SECS;
            end
            tcc_pkg::OP_LOAD_MIN:
            begin
                hour_next = dq_reg[4:0];
                dq_next   = {rem_reg[11:0], 52'd0};
                rem_next  = 24'd0;
                div_next  = tcc_pkg::MIN_SECS;
            end
            tcc_pkg::OP_SAVE_TIME:
            begin
                min_next = dq_reg[5:0];
                sec_next = rem_reg[5:0];
            end
            tcc_pkg::OP_CENT:
            begin
                days_next     = days_reg - tcc_pkg::CENT_DAYS;
                yr_next       = yr_reg + 16'd100;
                cent_idx_next = cent_idx_reg + 2'd1;
            end
            tcc_pkg::OP_QUAD:
            begin
                days_next     = days_reg - tcc_pkg::QUAD_DAYS;
                yr_next       = yr_reg + 16'd4;
                quad_idx_next = quad_idx_reg + 5'd1;
            end
            tcc_pkg::OP_YEAR:
            begin
                days_next   = days_reg - tcc_pkg::YEAR_DAYS;
                yr_next     = yr_reg + 16'd1;
                yr_idx_next = yr_idx_reg + 2'd1;
            end
            tcc_pkg::OP_MON:
            begin
                days_next = days_reg - {13'd0, mlen};
                mon_next  = mon_reg + 4'd1;
            end
            tcc_pkg::OP_PUBLISH:
            begin
                year_next   = yr_reg;
                month_next  = mon_reg + 4'd1;
                dom_next    = days_reg[4:0] + 5'd1;
                h12_next    = (hour_lo == 5'd0) ? 4'd12 : hour_lo[3:0];
                minute_next = min_reg;
                second_next = sec_reg;
                pm_next     = hour_pm;
            end
            default:
            begin
            end
        endcase
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        tod_reg      <= tod_next;
        hour_reg     <= hour_next;
        min_reg      <= min_next;
        sec_reg      <= sec_next;
        yr_reg       <= yr_next;
        days_reg     <= days_next;
        cent_idx_reg <= cent_idx_next;
        quad_idx_reg <= quad_idx_next;
        yr_idx_reg   <= yr_idx_next;
        mon_reg      <= mon_next;
        year_reg     <= year_next;
        month_reg    <= month_next;
        dom_reg      <= dom_next;
        h12_reg      <= h12_next;
        minute_reg   <= minute_next;
        second_reg   <= second_next;
        pm_reg       <= pm_next;
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign hour_twelve  = h12_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign is_pm        = pm_reg;

endmodule

`default_nettype wire

### sv/tcc_ctrl.sv
// tcc_ctrl: sequencer for the tick count to calendar block. Runs the division
// passes and the calendar walk, owns both handshakes. Uses tcc_pkg.
`default_nettype none

module tcc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ticks_valid,
    output logic                   ticks_stall,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output tcc_pkg::dp_cmd_t       cmd,
    input  wire tcc_pkg::dp_stat_t stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_CENT = 3'd3;
    localparam logic [2:0] S_QUAD = 3'd4;
    localparam logic [2:0] S_YEAR = 3'd5;
    localparam logic [2:0] S_MON  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [2:0] PH_SEC = 3'd0;
    localparam logic [2:0] PH_DAY = 3'd1;
    localparam logic [2:0] PH_CYC = 3'd2;
    localparam logic [2:0] PH_HR  = 3'd3;
    localparam logic [2:0] PH_MIN = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       rvalid_reg, rvalid_next;
    logic       publish;

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd.op     = tcc_pkg::OP_NONE;
        publish    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ticks_valid)
                begin
                    cmd.op     = tcc_pkg::OP_LOAD_IN;
                    cnt_next   = tcc_pkg::STEPS_SEC;
                    phase_next = PH_SEC;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op   = tcc_pkg::OP_STEP;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
                unique case (phase_reg)
                    PH_SEC:
                    begin
                        cmd.op     = tcc_pkg::OP_LOAD_DAY;
                        cnt_next   = tcc_pkg::STEPS_DAY;
                        phase_next = PH_DAY;
                    end
                    PH_DAY:
                    begin
                        cmd.op     = tcc_pkg::OP_LOAD_CYC;
                        cnt_next   = tcc_pkg::STEPS_CYC;
                        phase_next = PH_CYC;
                    end
                    PH_CYC:
                    begin
                        cmd.op     = tcc_pkg::OP_LOAD_HR;
                        cnt_next   = tcc_pkg::STEPS_HR;
                        phase_next = PH_HR;
                    end
                    PH_HR:
                    begin
                        cmd.op     = tcc_pkg::OP_LOAD_MIN;
                        cnt_next   = tcc_pkg::STEPS_MIN;
                        phase_next = PH_MIN;
                    end
                    default:
                    begin
                        cmd.op     = tcc_pkg::OP_SAVE_TIME;
                        state_next = S_CENT;
                    end
                endcase
            end
            S_CENT:
            begin
                if (stat.cent_more)
                    cmd.op = tcc_pkg::OP_CENT;
                else
                    state_next = S_QUAD;
            end
            S_QUAD:
            begin
                if (stat.quad_more)
                    cmd.op = tcc_pkg::OP_QUAD;
                else
                    state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (stat.year_more)
                    cmd.op = tcc_pkg::OP_YEAR;
                else
                    state_next = S_MON;
            end
            S_MON:
            begin
                if (stat.mon_more)
                    cmd.op = tcc_pkg::OP_MON;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!rvalid_reg || !result_stall)
                begin
                    cmd.op     = tcc_pkg::OP_PUBLISH;
                    publish    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on publish, cleared when taken
    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (publish)
            rvalid_next = 1'b1;
        else if (rvalid_reg && !result_stall)
            rvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_SEC;
            cnt_reg    <= 5'd0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign ticks_stall  = (state_reg != S_IDLE);
    assign result_valid = rvalid_reg;

endmodule

`default_nettype wire

### sv/tcc_checker.sv
// tcc_checker: port-level checks for tick_count_to_calendar, bound to the
// top level below. Sees only the top level's ports.
`default_nettype none

module tcc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        ticks_valid,
    input wire logic        ticks_stall,
    input wire logic [63:0] ticks,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [15:0] year,
    input wire logic [3:0]  month,
    input wire logic [4:0]  day_of_month,
    input wire logic [3:0]  hour_twelve,
    input wire logic [5:0]  minute,
    input wire logic [5:0]  second,
    input wire logic        is_pm
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(year) && $stable(month)
        && $stable(day_of_month) && $stable(hour_twelve) && $stable(minute)
        && $stable(second) && $stable(is_pm))
        else $error("stalled result changed");

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_valid && !ticks_stall |=> ticks_stall)
        else $error("input taken again right after acceptance");

    // date fields in range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
        && year >= 16'd1601)
        else $error("date field out of range");

    // time fields in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hour_twelve >= 4'd1 && hour_twelve <= 4'd12
        && minute < 6'd60 && second < 6'd60)
        else $error("time field out of range");

endmodule

bind tick_count_to_calendar tcc_checker u_tcc_checker (.*);

`default_nettype wire

### tb/sv/tick_count_to_calendar_tb.sv
// Testbench for tick_count_to_calendar: directed and random tick counts, with
// a scoreboard class that predicts each calendar result and checks it.
// Depends on the tick_count_to_calendar RTL (and its tcc_pkg) only.
`default_nettype none

module tick_count_to_calendar_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 150;
    localparam int IDLE_PERCENT  = 15;
    localparam logic [63:0] TICKS_PER_SEC = 64'd10_000_000;

    typedef struct packed {
        logic [15:0] yr;
        logic [3:0]  mon;
        logic [4:0]  mday;
        logic [3:0]  hr12;
        logic [5:0]  mins;
        logic [5:0]  secs;
        logic        pm;
    } cal_t;

    logic        clk;
    logic        rst_n;
    logic        ticks_valid;
    logic        ticks_stall;
    logic [63:0] ticks;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [3:0]  hour_twelve;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        is_pm;

    // shared between the stimulus, stall, monitor and run-limit processes
    bit quiet;
    bit hold_req;
    int holds_done;
    int input_stalls;
    int cycle_count;

    tick_count_to_calendar uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .ticks_valid  (ticks_valid),
        .ticks_stall  (ticks_stall),
        .ticks        (ticks),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour_twelve  (hour_twelve),
        .minute       (minute),
        .second       (second),
        .is_pm        (is_pm)
    );

    // gregorian leap rule
    function automatic bit is_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // days in month, month 0 is january
    function automatic int unsigned month_days(int unsigned m0, bit lp);
        case (m0)
            1:          return lp ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
        endcase
    endfunction

    // tick count for a given date and time of day, years 1601 and later
    function automatic logic [63:0] ticks_of(int unsigned y, int unsigned m,
                                             int unsigned d, int unsigned tod,
                                             int unsigned sub);
        int unsigned n;
        logic [63:0] days;
        n = y - 1601;
        days = 64'(n * 365 + n / 4 - n / 100 + n / 400);
        for (int unsigned k = 0; k < m - 1; k++)
            days = days + 64'(month_days(k, is_leap(y)));
        days = days + 64'(d) - 64'd1;
        return (days * 64'd86400 + 64'(tod)) * TICKS_PER_SEC + 64'(sub);
    endfunction

    class cal_scoreboard;
        cal_t        want_q[$];
        logic [63:0] src_q[$];
        int          errors;
        int          n_items;
        int          n_checked;
        int          n_pm;
        int          n_leap_day;

        function new();
            errors = 0;
            n_items = 0;
            n_checked = 0;
            n_pm = 0;
            n_leap_day = 0;
        endfunction

        // calendar fields for one tick count
        function cal_t to_calendar(logic [63:0] t);
            logic [63:0] whole_secs;
            logic [63:0] day_count;
            int unsigned tod;
            int unsigned hr;
            int unsigned yr;
            int unsigned rem_days;
            int unsigned mon;
            bit          lp;
            cal_t        c;
            whole_secs = t / TICKS_PER_SEC;
            day_count = whole_secs / 64'd86400;
            tod = 32'(whole_secs % 64'd86400);
            hr = tod / 3600;
            c.mins = 6'((tod % 3600) / 60);
            c.secs = 6'(tod % 60);
            yr = 32'(64'd1601 + 64'd400 * (day_count / 64'd146097));
            rem_days = 32'(day_count % 64'd146097);
            // year walk, bounded by one 400-year cycle
            for (int g = 0; g < 401; g++)
            begin
                if (rem_days < (is_leap(yr) ? 366 : 365))
                    break;
                rem_days = rem_days - (is_leap(yr) ? 366 : 365);
                yr++;
            end
            lp = is_leap(yr);
            mon = 0;
            while (mon < 11 && rem_days >= month_days(mon, lp))
            begin
                rem_days = rem_days - month_days(mon, lp);
                mon++;
            end
            c.pm = (hr >= 12);
            if (hr >= 12)
                hr = hr - 12;
            if (hr == 0)
                hr = 12;
            c.yr = yr[15:0];
            c.mon = 4'(mon + 1);
            c.mday = 5'(rem_days + 1);
            c.hr12 = 4'(hr);
            return c;
        endfunction

        function void note_ticks(logic [63:0] t);
            want_q.push_back(to_calendar(t));
            src_q.push_back(t);
            n_items++;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void report_field(string name, logic [63:0] src,
                                   logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: ticks %0d: %s expected %0d, got %0d",
                     $time, src, name, want, got);
        endfunction

        function void check_result(cal_t got);
            cal_t        want;
            logic [63:0] src;
            if (want_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item outstanding, expected none, got %0d-%0d-%0d",
                         $time, got.yr, got.mon, got.mday);
                return;
            end
            want = want_q.pop_front();
            src = src_q.pop_front();
            n_checked++;
            if (want.pm)
                n_pm++;
            if (want.mon == 2 && want.mday == 29)
                n_leap_day++;
            if (got.yr !== want.yr)
                report_field("year", src, want.yr, got.yr);
            if (got.mon !== want.mon)
                report_field("month", src, 16'(want.mon), 16'(got.mon));
            if (got.mday !== want.mday)
                report_field("day_of_month", src, 16'(want.mday), 16'(got.mday));
            if (got.hr12 !== want.hr12)
                report_field("hour_twelve", src, 16'(want.hr12), 16'(got.hr12));
            if (got.mins !== want.mins)
                report_field("minute", src, 16'(want.mins), 16'(got.mins));
            if (got.secs !== want.secs)
                report_field("second", src, 16'(want.secs), 16'(got.secs));
            if (got.pm !== want.pm)
                report_field("is_pm", src, 16'(want.pm), 16'(got.pm));
        endfunction
    endclass

    cal_scoreboard sb;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("[tick_count_to_calendar] ERROR");
        $finish;
    end

    // receiver stall, random or a long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
                result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // result monitor and input stall count
    initial
    begin
        input_stalls = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && ticks_valid && ticks_stall)
                input_stalls++;
            if (rst_n && result_valid && !result_stall)
                sb.check_result('{year, month, day_of_month, hour_twelve,
                                  minute, second, is_pm});
        end
    end

    // offer one item, entered and left at a falling edge
    task automatic send_item(logic [63:0] t);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            ticks_valid <= 1'b0;
            @(negedge clk);
        end
        ticks_valid <= 1'b1;
        ticks <= t;
        @(posedge clk);
        while (ticks_stall)
            @(posedge clk);
        sb.note_ticks(t);
        @(negedge clk);
    endtask

    // random tick count, mostly plausible dates with some wide noise
    function automatic logic [63:0] pick_ticks();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned tod;
        int unsigned sub;
        logic [63:0] days;
        sub = $urandom_range(0, 9_999_999);
        case ($urandom_range(0, 7))
            0: tod = 0;
            1: tod = 3599;
            2: tod = 3600;
            3: tod = 43199;
            4: tod = 43200;
            5: tod = 46799;
            6: tod = 86399;
            default: tod = $urandom_range(0, 86399);
        endcase
        case ($urandom_range(0, 9))
            0, 1:
                return {$urandom, $urandom};
            2:
                return ~64'd0 - ({32'd0, $urandom} << $urandom_range(0, 31));
            3:
                return {$urandom, $urandom} >> $urandom_range(1, 63);
            4, 5, 6:
            begin
                days = 64'($urandom_range(0, 500_000));
                return (days * 64'd86400 + 64'($urandom_range(0, 86399))) * TICKS_PER_SEC
                       + 64'(sub);
            end
            default:
            begin
                // month and year boundaries
                y = $urandom_range(1601, 9999);
                m = $urandom_range(1, 12);
                case ($urandom_range(0, 6))
                    0: begin m = 1; d = 1; end
                    1: begin m = 2; d = 28; end
                    2: begin m = is_leap(y) ? 2 : 3; d = is_leap(y) ? 29 : 1; end
                    3: begin m = 3; d = 1; end
                    4: begin m = 12; d = 31; end
                    5: d = $urandom_range(1, 28);
                    default: d = month_days(m - 1, is_leap(y));
                endcase
                return ticks_of(y, m, d, tod, sub);
            end
        endcase
    endfunction

    // stimulus
    initial
    begin
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        ticks_valid = 1'b0;
        ticks = 64'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, sub-second truncation, noon and midnight, leap rules
        send_item(64'd0);
        send_item(64'd9_999_999);
        send_item(64'd10_000_000);
        send_item(ticks_of(1601, 1, 1, 43199, 9_999_999));
        send_item(ticks_of(1601, 1, 1, 43200, 0));
        send_item(ticks_of(1601, 1, 1, 86399, 9_999_999));
        send_item(ticks_of(1601, 12, 31, 3600, 0));
        send_item(ticks_of(1604, 2, 29, 46799, 5));
        send_item(ticks_of(1604, 12, 31, 86399, 0));
        send_item(ticks_of(1700, 2, 28, 12345, 0));
        send_item(ticks_of(1700, 3, 1, 0, 0));
        send_item(ticks_of(2000, 2, 29, 59, 1));
        send_item(ticks_of(2000, 12, 31, 43200, 0));
        send_item(ticks_of(2001, 1, 1, 0, 0));
        send_item(ticks_of(2024, 7, 15, 52245, 9_999_999));
        send_item(ticks_of(2100, 3, 1, 3599, 0));
        send_item(ticks_of(2400, 2, 29, 82800, 0));
        send_item(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'h8000_0000_0000_0000);
        send_item(64'h7FFF_FFFF_FFFF_FFFF);
        send_item(64'hAAAA_AAAA_AAAA_AAAA);
        send_item(64'h5555_5555_5555_5555);
        send_item(64'h0000_0000_FFFF_FFFF);

        // random items with a hold-off, a full drain and a quiet stretch
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
                hold_req = 1'b1;
            if (i == 600)
            begin
                ticks_valid <= 1'b0;
                @(negedge clk);
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            quiet = (i >= 800 && i < 1050);
            send_item(pick_ticks());
        end
        quiet = 1'b0;
        ticks_valid <= 1'b0;

        // drain, then watch for stray results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results for %0d items: %0d afternoon times, %0d leap days",
                 sb.n_checked, sb.n_items, sb.n_pm, sb.n_leap_day);
        $display("input stalled %0d cycles, %0d long receiver hold-offs, %0d cycles total",
                 input_stalls, holds_done, cycle_count);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[tick_count_to_calendar] OK");
        else
            $display("[tick_count_to_calendar] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
